[rtl/ray_box_entry_distance_defines.svh]
// Assertion macros for the ray/box entry distance block.
// Used by the top level; needs nothing else.
`ifndef RAY_BOX_ENTRY_DISTANCE_DEFINES_SVH
`define RAY_BOX_ENTRY_DISTANCE_DEFINES_SVH
`ifndef SYNTHESIS
`define RBED_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rbed assertion failed");
`define RBED_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rbed assertion failed");
`else
`define RBED_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RBED_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/rbed_pkg.sv]
// Shared types, constants and the box interval test.
// No dependencies.
`default_nettype none
package rbed_pkg;

  localparam int unsigned PosW  = 66;  // width of hit point coordinates
  localparam int unsigned SizeW = 31;

  typedef enum logic [2:0] {
    CFG_MODE   = 3'd0,
    CFG_POS_X  = 3'd1,
    CFG_POS_Y  = 3'd2,
    CFG_POS_Z  = 3'd3,
    CFG_SIZE_X = 3'd4,
    CFG_SIZE_Y = 3'd5,
    CFG_SIZE_Z = 3'd6
  } cfg_idx_e;

  // Per-axis box description handed to the face and span units
  typedef struct packed {
    logic             center;
    logic [SizeW-1:0] size;
  } face_ctl_t;

  // Interval test: inclusive around a centre, strict from a corner
  function automatic logic in_extent(input logic signed [PosW-1:0] p,
                                     input logic [SizeW-1:0] s,
                                     input logic center);
    logic signed [PosW-1:0] sp;
    sp = $signed({{(PosW-SizeW){1'b0}}, s});
    if (center) begin
      in_extent = (p >= -sp) && (p <= sp);
    end else begin
      in_extent = (p > 0) && (p < sp);
    end
  endfunction

endpackage
`default_nettype wire

[rtl/ray_box_entry_distance.sv]
// Ray versus axis-aligned box entry distance, fixed point.
// Throughput: one item per cycle; busy_o is always low and results cannot be stalled.
// The depth is set by the two multiply stages (offset * reciprocal, dir * t).
// Reset clears the valid pipeline and loads the box registers with their defaults.
`default_nettype none
module ray_box_entry_distance #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic signed [31:0] origin_x_i,
  input  wire logic signed [31:0] origin_y_i,
  input  wire logic signed [31:0] origin_z_i,
  input  wire logic signed [31:0] dir_x_i,
  input  wire logic signed [31:0] dir_y_i,
  input  wire logic signed [31:0] dir_z_i,
  input  wire logic signed [31:0] recip_x_i,
  input  wire logic signed [31:0] recip_y_i,
  input  wire logic signed [31:0] recip_z_i,
  output logic                    done_o,
  output logic                    hit_o,
  output logic [30:0]             distance_o
);
  import rbed_pkg::*;

  `include "ray_box_entry_distance_defines.svh"

  logic accept;

  // box registers
  logic               mode_q;
  logic signed [31:0] pos_q  [3];
  logic [30:0]        size_q [3];
  face_ctl_t          ctl [3];

  logic [6:0] v_q;

  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  logic signed [31:0] rcp [3];

  logic signed [32:0] rel1_q [3];
  logic signed [31:0] dir1_q [3];
  logic signed [31:0] rcp1_q [3];
  logic signed [32:0] rel2_q [3];
  logic signed [32:0] rel3_q [3];
  logic signed [32:0] rel4_q [3];
  logic signed [31:0] dir2_q [3];
  logic signed [31:0] dir3_q [3];
  logic signed [31:0] dir4_q [3];
  logic [4:0]         inside_q;  // inside flag, stages 2..6

  logic signed [31:0] t4 [3];
  logic signed [31:0] t5_q [3];
  logic signed [31:0] t6_q [3];
  logic [1:0]         span_ok [3];

  logic        hit_d, hit_q;
  logic [30:0] dist_d, dist_q;

  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;

  assign org = '{origin_x_i, origin_y_i, origin_z_i};
  assign dir = '{dir_x_i, dir_y_i, dir_z_i};
  assign rcp = '{recip_x_i, recip_y_i, recip_z_i};

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i]  <= '0;
        size_q[i] <= 31'd65536;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:   mode_q    <= cfg_data_i[0];
        CFG_POS_X:  pos_q[0]  <= cfg_data_i;
        CFG_POS_Y:  pos_q[1]  <= cfg_data_i;
        CFG_POS_Z:  pos_q[2]  <= cfg_data_i;
        CFG_SIZE_X: size_q[0] <= cfg_data_i[30:0];
        CFG_SIZE_Y: size_q[1] <= cfg_data_i[30:0];
        CFG_SIZE_Z: size_q[2] <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ctl[i].center = mode_q;
      ctl[i].size   = size_q[i];
    end
  end

  // Valid bits travel alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[5:0], accept};
    end
  end

  // Stage 1: relative origin; later stages carry what the span checks need
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      rel1_q[i] <= 33'(org[i]) - 33'(pos_q[i]);
      dir1_q[i] <= dir[i];
      rcp1_q[i] <= rcp[i];
      rel2_q[i] <= rel1_q[i];
      rel3_q[i] <= rel2_q[i];
      rel4_q[i] <= rel3_q[i];
      dir2_q[i] <= dir1_q[i];
      dir3_q[i] <= dir2_q[i];
      dir4_q[i] <= dir3_q[i];
      t5_q[i]   <= t4[i];
      t6_q[i]   <= t5_q[i];
    end
    inside_q[0] <= in_extent(PosW'(rel1_q[0]), size_q[0], mode_q) &&
                   in_extent(PosW'(rel1_q[1]), size_q[1], mode_q) &&
                   in_extent(PosW'(rel1_q[2]), size_q[2], mode_q);
    inside_q[4:1] <= inside_q[3:0];
  end

  // Face distances and hit point checks on the two other axes
  for (genvar a = 0; a < 3; a++) begin : g_face
    localparam int unsigned B = (a == 0) ? 1 : 0;
    localparam int unsigned C = (a == 2) ? 1 : 2;

    rbed_face_dist #(.FRAC_BITS(FRAC_BITS)) u_face (
      .clk_i     (clk_i),
      .ctl_i     (ctl[a]),
      .rel_i     (rel1_q[a]),
      .dir_neg_i (dir1_q[a][31]),
      .rcp_i     (rcp1_q[a]),
      .t_o       (t4[a])
    );

    rbed_span_chk #(.FRAC_BITS(FRAC_BITS)) u_span_b (
      .clk_i (clk_i),
      .ctl_i (ctl[B]),
      .dir_i (dir4_q[B]),
      .t_i   (t4[a]),
      .rel_i (rel4_q[B]),
      .ok_o  (span_ok[a][0])
    );

    rbed_span_chk #(.FRAC_BITS(FRAC_BITS)) u_span_c (
      .clk_i (clk_i),
      .ctl_i (ctl[C]),
      .dir_i (dir4_q[C]),
      .t_i   (t4[a]),
      .rel_i (rel4_q[C]),
      .ok_o  (span_ok[a][1])
    );
  end

  // Final stage: inside first, then the first face in x, y, z order
  always_comb begin
    hit_d  = 1'b0;
    dist_d = '0;
    priority if (inside_q[4]) begin
      hit_d = 1'b1;
    end else if (&span_ok[0]) begin
      hit_d  = (t6_q[0] > 0);
      dist_d = hit_d ? t6_q[0][30:0] : '0;
    end else if (&span_ok[1]) begin
      hit_d  = (t6_q[1] > 0);
      dist_d = hit_d ? t6_q[1][30:0] : '0;
    end else if (&span_ok[2]) begin
      hit_d  = (t6_q[2] > 0);
      dist_d = hit_d ? t6_q[2][30:0] : '0;
    end else begin
      hit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q  <= hit_d;
    dist_q <= dist_d;
  end

  assign done_o     = v_q[6];
  assign hit_o      = hit_q;
  assign distance_o = dist_q;

  // A miss never carries a distance
  `RBED_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, done_o && !hit_o, distance_o == '0)
  // Every result stems from an item taken on start_i
  `RBED_ASSERT_IMP(a_done_src, clk_i, rst_ni, done_o, $past(start_i, 7))
  // An origin inside the box reports distance zero in the following cycle
  `RBED_ASSERT_NXT(a_inside_zero, clk_i, rst_ni, v_q[5] && inside_q[4], hit_o && distance_o == '0)

endmodule
`default_nettype wire

[rtl/rbed_face_dist.sv]
// Entry distance to one face: offset, scaled by the reciprocal, saturated.
// Three register stages. Depends on rbed_pkg.
`default_nettype none
module rbed_face_dist #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire rbed_pkg::face_ctl_t   ctl_i,
  input  wire logic signed [32:0]    rel_i,
  input  wire logic                  dir_neg_i,
  input  wire logic signed [31:0]    rcp_i,
  output logic signed [31:0]         t_o
);
  import rbed_pkg::*;

  logic signed [34:0] off;
  logic signed [34:0] near;
  logic [33:0] off_mag_d, off_mag_q;
  logic [31:0] rcp_mag_d, rcp_mag_q;
  logic        neg_d, neg2_q, neg3_q;
  logic [65:0] prod_q;
  logic [65:0] quo;
  logic [32:0] neg_val;
  logic signed [31:0] t_d, t_q;

  // Stage 1: face offset and operand magnitudes
  always_comb begin
    near = $signed({4'b0, ctl_i.size});
    if (ctl_i.center) begin
      off = (dir_neg_i ? near : -near) - 35'(rel_i);
    end else begin
      off = (dir_neg_i ? near : 35'sd0) - 35'(rel_i);
    end
    off_mag_d = off[34] ? 34'(-off) : off[33:0];
    rcp_mag_d = rcp_i[31] ? 32'(-rcp_i) : rcp_i;
    neg_d     = off[34] ^ rcp_i[31];
  end

  always_ff @(posedge clk_i) begin
    off_mag_q <= off_mag_d;
    rcp_mag_q <= rcp_mag_d;
    neg2_q    <= neg_d;
  end

  // Stage 2: magnitude product
  always_ff @(posedge clk_i) begin
    prod_q <= 66'(off_mag_q) * 66'(rcp_mag_q);
    neg3_q <= neg2_q;
  end

  // Stage 3: drop fraction bits, saturate to 32-bit signed
  always_comb begin
    quo     = prod_q >> FRAC_BITS;
    neg_val = 33'd0 - quo[32:0];
    if (neg3_q) begin
      t_d = (quo > 66'h0_8000_0000) ? 32'sh8000_0000 : $signed(neg_val[31:0]);
    end else begin
      t_d = (quo > 66'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(quo[31:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
  end

  assign t_o = t_q;

endmodule
`default_nettype wire

[rtl/rbed_span_chk.sv]
// Hit point along one axis at a given t, tested against the box extent.
// Two register stages. Depends on rbed_pkg.
`default_nettype none
module rbed_span_chk #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire rbed_pkg::face_ctl_t   ctl_i,
  input  wire logic signed [31:0]    dir_i,
  input  wire logic signed [31:0]    t_i,
  input  wire logic signed [32:0]    rel_i,
  output logic                       ok_o
);
  import rbed_pkg::*;

  logic [31:0] dir_mag, t_mag;
  logic [63:0] pm_q;
  logic        neg_q;
  logic signed [32:0] rel_q;
  logic [63:0] quo;
  logic signed [PosW-1:0] step, pt;
  logic ok_q;

  // Stage 1: |dir| * |t|
  assign dir_mag = dir_i[31] ? 32'(-dir_i) : dir_i;
  assign t_mag   = t_i[31] ? 32'(-t_i) : t_i;

  always_ff @(posedge clk_i) begin
    pm_q  <= 64'(dir_mag) * 64'(t_mag);
    neg_q <= dir_i[31] ^ t_i[31];
    rel_q <= rel_i;
  end

  // Stage 2: signed step plus relative origin, then the extent test
  always_comb begin
    quo  = pm_q >> FRAC_BITS;
    step = $signed({{(PosW-64){1'b0}}, quo});
    if (neg_q) begin
      step = -step;
    end
    pt = step + PosW'(rel_q);
  end

  always_ff @(posedge clk_i) begin
    ok_q <= in_extent(pt, ctl_i.size, ctl_i.center);
  end

  assign ok_o = ok_q;

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for the ray/box entry distance block.
// Needs rbed_pkg and ray_box_entry_distance; no files, no arguments.
`default_nettype none
module tb_top;
  import rbed_pkg::*;

  localparam int unsigned FRAC  = 16;
  localparam longint      TMAX  = 64'sd2147483647;
  localparam longint      TMIN  = -64'sd2147483648;
  localparam logic [2:0]  CfgUnused = 3'd7;  // index with no register behind it
  localparam int          CycleLimit = 400000;

  // Expected-result store with its own copy of the box
  class box_scoreboard;
    bit          mode;
    longint      pos[3];
    longint      size[3];
    bit          hit_q[$];
    logic [30:0] dist_q[$];
    int          errors;

    function new();
      mode = 0;
      errors = 0;
      for (int a = 0; a < 3; a++) begin
        pos[a] = 0;
        size[a] = 65536;
      end
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_MODE:   mode = data[0];
        CFG_POS_X:  pos[0] = longint'($signed(data));
        CFG_POS_Y:  pos[1] = longint'($signed(data));
        CFG_POS_Z:  pos[2] = longint'($signed(data));
        CFG_SIZE_X: size[0] = longint'({33'd0, data[30:0]});
        CFG_SIZE_Y: size[1] = longint'({33'd0, data[30:0]});
        CFG_SIZE_Z: size[2] = longint'({33'd0, data[30:0]});
        default: ;
      endcase
    endfunction

    static function longint unsigned mag(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // offset * reciprocal >> FRAC, toward zero, saturated to 32 bits signed
    function longint face_t(longint off, longint rc);
      logic [127:0] p;
      bit neg;
      neg = (off < 0) != (rc < 0);
      p = ({64'd0, mag(off)} * {64'd0, mag(rc)}) >> FRAC;
      if (neg) return (p > 128'h8000_0000) ? TMIN : -longint'(p[63:0]);
      return (p > 128'h7FFF_FFFF) ? TMAX : longint'(p[63:0]);
    endfunction

    function longint hit_coord(longint d, longint t, longint r);
      longint unsigned q;
      q = (mag(d) * mag(t)) >> FRAC;
      return (((d < 0) != (t < 0)) ? -longint'(q) : longint'(q)) + r;
    endfunction

    function bit in_span(longint p, longint s);
      if (mode) return (p >= -s) && (p <= s);
      return (p > 0) && (p < s);
    endfunction

    // Work out the result of one accepted ray
    function void note_ray(logic [31:0] org[3], logic [31:0] dr[3], logic [31:0] rc[3]);
      longint rel[3], d[3], r[3], off, t;
      bit in_box;
      int b, c;
      bit h;
      logic [30:0] dist_e;
      in_box = 1;
      h = 0;
      dist_e = '0;
      for (int a = 0; a < 3; a++) begin
        rel[a] = longint'($signed(org[a])) - pos[a];
        d[a] = longint'($signed(dr[a]));
        r[a] = longint'($signed(rc[a]));
        if (!in_span(rel[a], size[a])) in_box = 0;
      end
      if (in_box) begin
        h = 1;
      end else begin
        for (int a = 0; a < 3; a++) begin
          b = (a == 0) ? 1 : 0;
          c = (a == 2) ? 1 : 2;
          if (mode) off = ((d[a] < 0) ? size[a] : -size[a]) - rel[a];
          else off = ((d[a] < 0) ? size[a] : 0) - rel[a];
          t = face_t(off, r[a]);
          if (in_span(hit_coord(d[b], t, rel[b]), size[b]) &&
              in_span(hit_coord(d[c], t, rel[c]), size[c])) begin
            if (t > 0) begin
              h = 1;
              dist_e = t[30:0];
            end
            break;
          end
        end
      end
      hit_q.push_back(h);
      dist_q.push_back(dist_e);
    endfunction

    function void check_result(logic hit, logic [30:0] dist_a);
      bit eh;
      logic [30:0] ed;
      if (hit_q.size() == 0) begin
        $display("%0t: unexpected result hit=%0b distance=%h", $time, hit, dist_a);
        errors++;
        return;
      end
      eh = hit_q.pop_front();
      ed = dist_q.pop_front();
      if (hit !== eh) begin
        $display("%0t: hit mismatch, expected %0b, got %0b", $time, eh, hit);
        errors++;
      end
      if (dist_a !== ed) begin
        $display("%0t: distance mismatch, expected %h, got %h", $time, ed, dist_a);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, start, cfg_we;
  logic [2:0] cfg_idx;
  logic [31:0] cfg_data;
  logic signed [31:0] org_x, org_y, org_z, dir_x, dir_y, dir_z, rcp_x, rcp_y, rcp_z;
  logic busy, done, hit;
  logic [30:0] distance;
  int cycles;
  box_scoreboard sb;

  ray_box_entry_distance uut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .origin_x_i(org_x), .origin_y_i(org_y), .origin_z_i(org_z),
    .dir_x_i(dir_x), .dir_y_i(dir_y), .dir_z_i(dir_z),
    .recip_x_i(rcp_x), .recip_y_i(rcp_y), .recip_z_i(rcp_z),
    .done_o(done), .hit_o(hit), .distance_o(distance)
  );

  // Clock and watchdog
  initial begin
    clk = 0;
    cycles = 0;
    forever begin
      #4 clk = ~clk;
      if (clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
          $display("FAIL ray_box_entry_distance");
          $finish;
        end
      end
    end
  end

  // Note accepted rays, check strobed results
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      sb.note_ray('{org_x, org_y, org_z}, '{dir_x, dir_y, dir_z}, '{rcp_x, rcp_y, rcp_z});
    if (rst_n && done) sb.check_result(hit, distance);
  end

  // Saturated Q16.16 reciprocal; zero direction counts as positive
  function automatic logic [31:0] recip_of(logic signed [31:0] d);
    longint q;
    if (d == 0) return 32'h7FFF_FFFF;
    q = (64'sd1 <<< 32) / longint'(d);
    if (q > TMAX) return 32'h7FFF_FFFF;
    if (q < TMIN) return 32'h8000_0000;
    return q[31:0];
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > TMAX) return 32'h7FFF_FFFF;
    if (v < TMIN) return 32'h8000_0000;
    return v[31:0];
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    sb.set_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for the pipeline to drain before touching the box
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.hit_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_box(bit m, logic [31:0] p[3], logic [31:0] s[3]);
    write_reg(CFG_MODE, {31'd0, m});
    write_reg(CFG_POS_X, p[0]);
    write_reg(CFG_POS_Y, p[1]);
    write_reg(CFG_POS_Z, p[2]);
    write_reg(CFG_SIZE_X, s[0]);
    write_reg(CFG_SIZE_Y, s[1]);
    write_reg(CFG_SIZE_Z, s[2]);
  endtask

  // Present one item after a gap; start stays high across back-to-back items
  task automatic send_ray(int gap, logic [31:0] o[3], logic [31:0] d[3], logic [31:0] r[3]);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    org_x <= o[0]; org_y <= o[1]; org_z <= o[2];
    dir_x <= d[0]; dir_y <= d[1]; dir_z <= d[2];
    rcp_x <= r[0]; rcp_y <= r[1]; rcp_z <= r[2];
    do @(posedge clk); while (busy);
  endtask

  task automatic send_aimed(int gap, logic [31:0] d[3]);
    logic [31:0] o[3], r[3];
    for (int a = 0; a < 3; a++) r[a] = recip_of(d[a]);
    o = '{32'd0, 32'd0, 32'd0};
    send_ray(gap, o, d, r);
  endtask

  // Random rays for the current box: mostly aimed near it, some pure noise
  task automatic random_rays(int count, bit gaps);
    logic [31:0] o[3], d[3], r[3];
    longint tgt, org, span;
    int sh, kind, gap;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      gap = (gaps && $urandom_range(0, 3) != 0) ? $urandom_range(0, 11) : 0;
      sh = $urandom_range(0, 8);
      for (int a = 0; a < 3; a++) begin
        span = (sb.size[a] > 0) ? sb.size[a] : 64'd65536;
        if (sb.mode) tgt = sb.pos[a] - span + longint'($urandom_range(0, 1000)) * span * 2 / 1000;
        else tgt = sb.pos[a] + longint'($urandom_range(0, 1000)) * span / 1000;
        org = tgt + (longint'($signed($urandom())) >>> (4 + sh)) * ((kind < 10) ? 0 : 1);
        o[a] = clip32(org);
        d[a] = clip32((tgt - longint'($signed(o[a]))) >>> $urandom_range(0, 3));
        r[a] = recip_of(d[a]);
        if (kind >= 85) begin
          o[a] = $urandom(); d[a] = $urandom(); r[a] = $urandom();
        end else if (kind >= 75) begin
          r[a] = $urandom();
        end else if (kind >= 70) begin
          d[a] = '0;
          r[a] = 32'h7FFF_FFFF;
        end
      end
      send_ray(gap, o, d, r);
    end
  endtask

  initial begin
    logic [31:0] z3[3], o[3], d[3], r[3];
    sb = new();
    rst_n = 0; start = 0; cfg_we = 0; cfg_idx = CFG_MODE; cfg_data = '0;
    org_x = 0; org_y = 0; org_z = 0; dir_x = 0; dir_y = 0; dir_z = 0;
    rcp_x = 0; rcp_y = 0; rcp_z = 0;
    z3 = '{32'd0, 32'd0, 32'd0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset box, origin inside, zero directions, faces, extremes
    o = '{32'h8000, 32'h8000, 32'h8000};
    send_ray(0, o, z3, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_ray(0, z3, z3, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_ray(0, '{-32'sh10000, 32'h8000, 32'h8000}, '{32'h10000, 0, 0},
             '{32'h10000, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_ray(0, '{32'h8000, -32'sh20000, 32'h8000}, '{0, 32'h10000, 0},
             '{32'h7FFF_FFFF, 32'h10000, 32'h7FFF_FFFF});
    send_ray(0, '{32'h8000, 32'h8000, 32'h30000}, '{0, 0, -32'sh10000},
             '{32'h7FFF_FFFF, 32'h7FFF_FFFF, -32'sh10000});
    send_ray(0, '{32'h20000, 32'h8000, 32'h8000}, '{32'h10000, 0, 0},
             '{32'h10000, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    o = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    d = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    send_ray(0, o, d, d);
    send_ray(0, d, o, o);
    send_ray(0, o, '{1, 1, 1}, d);
    send_aimed(0, '{32'hFFFF_FFFF, 32'h8000_0000, 32'h1});
    drain();
    write_reg(CfgUnused, 32'hFFFF_FFFF);
    set_box(1, z3, '{32'h10000, 32'h10000, 32'h10000});
    send_ray(0, '{32'h10000, -32'sh10000, 32'h10000}, z3, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_ray(0, '{-32'sh30000, 0, 0}, '{32'h10000, 0, 0}, '{32'h10000, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_ray(0, '{32'h30000, 0, 0}, '{32'h10000, 0, 0}, '{32'h10000, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_ray(0, '{0, 0, 32'h50000}, '{0, 0, -32'sh10000}, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, -32'sh10000});
    send_ray(0, o, d, d);
    drain();

    // Random phases over several boxes, extremes among them
    random_rays(250, 1);
    drain();
    set_box(0, '{32'hFFF0_0000, 32'h0010_0000, 32'h0}, '{32'h0020_0000, 32'h0000_8000, 32'h0100_0000});
    random_rays(250, 0);
    drain();
    set_box(1, '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0}, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    random_rays(200, 1);
    drain();
    set_box(0, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678}, '{32'h0, 32'h7FFF_FFFF, 32'h1});
    random_rays(200, 1);
    drain();
    set_box(1, '{32'h0003_0000, 32'hFFFD_0000, 32'h0}, '{32'h0, 32'h0001_0000, 32'h0004_0000});
    random_rays(250, 0);
    drain();
    set_box(1, '{32'h0100_0000, 32'hFF00_0000, 32'h0000_8000}, '{32'h0080_0000, 32'h0002_0000, 32'h0040_0000});
    random_rays(300, 1);
    drain();
    set_box(0, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    random_rays(280, 1);

    // Drain and report
    drain();
    if (sb.errors == 0) begin
      $display("PASS ray_box_entry_distance");
    end else begin
      $display("FAIL ray_box_entry_distance");
    end
    $finish;
  end

endmodule
`default_nettype wire
